// ===== rtl/hbs_pkg.sv =====
package hbs_pkg;

	localparam int LEVELS_DEF = 10;
	localparam int OP_W       = 3;
	localparam int KEY_W      = 10;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 16;

	localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
	localparam logic [OP_W-1:0] OP_REMOVE   = 3'd1;
	localparam logic [OP_W-1:0] OP_CONTAINS = 3'd2;
	localparam logic [OP_W-1:0] OP_MIN      = 3'd3;
	localparam logic [OP_W-1:0] OP_SUCC     = 3'd4;

	typedef struct packed {
		logic load;
		logic rd;
		logic rd_child;
		logic wr;
		logic wr_bit;
		logic up;
		logic right;
		logic down;
		logic set_found;
		logic found_val;
		logic set_answer;
		logic out_load;
		logic clr_step;
	} cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            own;
		logic            sib;
		logic            is_root;
		logic            is_leaf;
		logic            odd;
		logic            clr_last;
		logic            out_busy;
	} sts_t;

endpackage

// ===== rtl/hbs_ram.sv =====
module hbs_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/hbs_ctrl.sv =====
module hbs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  hbs_pkg::sts_t sts,
	output hbs_pkg::cmd_t cmd
);

	import hbs_pkg::*;

	localparam logic [2:0] ST_CLR    = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_RD     = 3'd2;
	localparam logic [2:0] ST_CHK    = 3'd3;
	localparam logic [2:0] ST_DN_RD  = 3'd4;
	localparam logic [2:0] ST_DN_CHK = 3'd5;
	localparam logic [2:0] ST_DONE   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_RD;
				end
			end
			ST_RD: begin
				if (sts.op inside {OP_INSERT, OP_REMOVE, OP_CONTAINS, OP_MIN, OP_SUCC}) begin
					cmd.rd  = 1'b1;
					state_d = ST_CHK;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_CHK: begin
				case (sts.op)
					OP_INSERT: begin
						if (sts.own) begin
							state_d = ST_DONE;
						end else begin
							cmd.wr     = 1'b1;
							cmd.wr_bit = 1'b1;
							if (sts.is_root) begin
								state_d = ST_DONE;
							end else begin
								cmd.up  = 1'b1;
								state_d = ST_RD;
							end
						end
					end
					OP_REMOVE: begin
						cmd.wr = 1'b1;
						if (sts.is_root || sts.sib) begin
							state_d = ST_DONE;
						end else begin
							cmd.up  = 1'b1;
							state_d = ST_RD;
						end
					end
					OP_CONTAINS: begin
						cmd.set_found = 1'b1;
						cmd.found_val = sts.own;
						state_d       = ST_DONE;
					end
					OP_MIN: begin
						if (sts.own) begin
							cmd.set_found = 1'b1;
							cmd.found_val = 1'b1;
							state_d       = ST_DN_RD;
						end else begin
							state_d = ST_DONE;
						end
					end
					OP_SUCC: begin
						if (sts.is_root) begin
							state_d = ST_DONE;
						end else if (!sts.odd && sts.sib) begin
							cmd.right     = 1'b1;
							cmd.set_found = 1'b1;
							cmd.found_val = 1'b1;
							state_d       = ST_DN_RD;
						end else begin
							cmd.up  = 1'b1;
							state_d = ST_RD;
						end
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			ST_DN_RD: begin
				if (sts.is_leaf) begin
					cmd.set_answer = 1'b1;
					state_d        = ST_DONE;
				end else begin
					cmd.rd       = 1'b1;
					cmd.rd_child = 1'b1;
					state_d      = ST_DN_CHK;
				end
			end
			ST_DN_CHK: begin
				cmd.down = 1'b1;
				state_d  = ST_DN_RD;
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/hbs_dp.sv =====
module hbs_dp #(
	parameter int LEVELS = hbs_pkg::LEVELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [hbs_pkg::OP_W-1:0]      in_op,
	input  logic [hbs_pkg::KEY_W-1:0]     in_key,
	input  hbs_pkg::cmd_t                 cmd,
	output hbs_pkg::sts_t                 sts,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic                          out_found,
	output logic [hbs_pkg::KEY_W-1:0]     out_answer
);

	import hbs_pkg::*;

	localparam int NW = LEVELS + 1;

	logic [OP_W-1:0]   op_q;
	logic [NW-1:0]     node_q;
	logic              found_q;
	logic [KEY_W-1:0]  answer_q;
	logic [LEVELS-1:0] clr_q;
	logic              out_valid_q;
	logic              out_found_q;
	logic [KEY_W-1:0]  out_answer_q;

	logic [LEVELS-1:0] key_l;
	logic [KEY_W-1:0]  ans_l;
	logic [1:0]        rd_data;
	logic [1:0]        wr_pair;
	logic [LEVELS-1:0] wr_addr;
	logic [LEVELS-1:0] rd_addr;

	generate
		if (LEVELS > KEY_W) begin : g_wide
			assign key_l = {{(LEVELS-KEY_W){1'b0}}, in_key};
			assign ans_l = node_q[KEY_W-1:0];
		end else if (LEVELS == KEY_W) begin : g_same
			assign key_l = in_key;
			assign ans_l = node_q[KEY_W-1:0];
		end else begin : g_narrow
			assign key_l = in_key[LEVELS-1:0];
			assign ans_l = {{(KEY_W-LEVELS){1'b0}}, node_q[LEVELS-1:0]};
		end
	endgenerate

	// node i lives at word i>>1, bit i&1; root is node 1
	assign rd_addr = cmd.rd_child ? node_q[LEVELS-1:0] : node_q[LEVELS:1];
	assign wr_addr = cmd.clr_step ? clr_q : node_q[LEVELS:1];
	assign wr_pair = cmd.clr_step ? 2'b00 :
		(node_q[0] ? {cmd.wr_bit, rd_data[0]} : {rd_data[1], cmd.wr_bit});

	hbs_ram #(
		.WIDTH(2),
		.DEPTH(2 ** LEVELS)
	) u_ram (
		.clk    (clk),
		.wr_en  (cmd.wr | cmd.clr_step),
		.wr_addr(wr_addr),
		.wr_data(wr_pair),
		.rd_en  (cmd.rd),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		sts          = '0;
		sts.op       = op_q;
		sts.own      = rd_data[node_q[0]];
		sts.sib      = rd_data[~node_q[0]];
		sts.is_root  = (node_q == NW'(1));
		sts.is_leaf  = node_q[LEVELS];
		sts.odd      = node_q[0];
		sts.clr_last = &clr_q;
		sts.out_busy = out_valid_q & ~out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= in_op;
			found_q  <= 1'b0;
			answer_q <= '0;
			node_q   <= (in_op == OP_MIN) ? NW'(1) : {1'b1, key_l};
		end else begin
			if (cmd.up) begin
				node_q <= {1'b0, node_q[LEVELS:1]};
			end else if (cmd.right) begin
				node_q <= node_q + NW'(1);
			end else if (cmd.down) begin
				node_q <= {node_q[LEVELS-1:0], ~rd_data[0]};
			end
			if (cmd.set_found) begin
				found_q <= cmd.found_val;
			end
			if (cmd.set_answer) begin
				answer_q <= ans_l;
			end
		end
		if (cmd.out_load) begin
			out_found_q  <= found_q;
			out_answer_q <= answer_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + LEVELS'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_found  = out_found_q;
	assign out_answer = out_answer_q;

endmodule

// ===== rtl/hierarchical_bitmap_set_top.sv =====
// Set of integers 0 .. 2^LEVELS-1 held as a binary tree of bits in one RAM word per sibling pair.
// Each beat carries an opcode (insert, remove, contains, minimum, successor) and a key, and
// gives exactly one result beat. After reset the RAM is cleared one word a cycle, every word
// in turn, with s_axis_tready low. Every step of an item is a read of the tree RAM followed by
// a decision on its registered data. Contains reads a single word, insert and remove climb
// toward the root, minimum walks down from the root and successor goes up the tree, then
// down. One item is worked on at a time; a finished result waits in the output register
// while the next beat is taken.
module hierarchical_bitmap_set_top #(
	parameter int LEVELS = hbs_pkg::LEVELS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [hbs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // opcode, key
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [hbs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata   // found, answer
);

	import hbs_pkg::*;

	cmd_t             cmd;
	sts_t             sts;
	logic             out_found;
	logic [KEY_W-1:0] out_answer;

	hbs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	hbs_dp #(
		.LEVELS(LEVELS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_op     (s_axis_tdata[OP_W-1:0]),
		.in_key    (s_axis_tdata[OP_W+KEY_W-1:OP_W]),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_found (out_found),
		.out_answer(out_answer)
	);

	assign m_axis_tdata = {{(OUT_TDATA_W-KEY_W-1){1'b0}}, out_answer, out_found};

endmodule

// ===== bench/hbs_check.sv =====
module hbs_check #(
	parameter int LEVELS = hbs_pkg::LEVELS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [hbs_pkg::IN_TDATA_W-1:0] s_axis_tdata,   // opcode, key
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [hbs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // found, answer
	output int                             fail_count,
	output int                             pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import hbs_pkg::*;

	localparam int LEAVES = 1 << LEVELS;

	typedef struct packed {
		logic             found;
		logic [KEY_W-1:0] answer;
	} reply_t;

	bit     node_bit [2*LEAVES];
	reply_t replies_due [$];
	int     errs = 0;
	int     due_seen = 0;

	assign fail_count = errs;
	assign pending    = due_seen;

	function automatic int unsigned leftmost_leaf(int unsigned n);
		while (n < LEAVES) begin
			n = 2 * n;
			if (!node_bit[n]) begin
				n++;
			end
		end
		return n - LEAVES;
	endfunction

	function automatic reply_t tree_apply(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
		int unsigned n;
		bit          done;
		reply_t      r;
		r    = '0;
		done = 1'b0;
		n    = LEAVES + (int'(key) & (LEAVES - 1));
		case (op)
			OP_INSERT: begin
				while (n >= 1 && !node_bit[n]) begin
					node_bit[n] = 1'b1;
					n >>= 1;
				end
			end
			OP_REMOVE: begin
				while (!done) begin
					node_bit[n] = 1'b0;
					if (n == 1 || node_bit[n ^ 1]) begin
						done = 1'b1;
					end else begin
						n >>= 1;
					end
				end
			end
			OP_CONTAINS: begin
				r.found = node_bit[n];
			end
			OP_MIN: begin
				if (node_bit[1]) begin
					r.found  = 1'b1;
					r.answer = KEY_W'(leftmost_leaf(1));
				end
			end
			OP_SUCC: begin
				// climb until a set right sibling, then take its smallest leaf
				while (n > 1 && !done) begin
					if ((n & 1) == 0 && node_bit[n + 1]) begin
						r.found  = 1'b1;
						r.answer = KEY_W'(leftmost_leaf(n + 1));
						done     = 1'b1;
					end else begin
						n >>= 1;
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t got;
		reply_t want;
		if (!arst_n) begin
			foreach (node_bit[i]) begin
				node_bit[i] = 1'b0;
			end
			replies_due.delete();
			due_seen <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.found  = m_axis_tdata[0];
				got.answer = m_axis_tdata[1 +: KEY_W];
				if (replies_due.size() == 0) begin
					errs++;
					$display("%0t: result beat with none due, found %0d answer %0d",
						$time, got.found, got.answer);
				end else begin
					want = replies_due.pop_front();
					if (got.found !== want.found) begin
						errs++;
						$display("%0t: found mismatch, expected %0d, actual %0d",
							$time, want.found, got.found);
					end
					if (got.answer !== want.answer) begin
						errs++;
						$display("%0t: answer mismatch, expected %0d, actual %0d",
							$time, want.answer, got.answer);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				replies_due.push_back(tree_apply(s_axis_tdata[OP_W-1:0],
					s_axis_tdata[OP_W +: KEY_W]));
			end
			due_seen <= replies_due.size();
		end
	end

endmodule

// ===== bench/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import hbs_pkg::*;

	localparam int PAD_W       = IN_TDATA_W - KEY_W - OP_W;
	localparam int KEY_MAX     = (1 << KEY_W) - 1;
	localparam int HOLD_AT     = 150;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 4000;
	localparam logic [OP_W-1:0] OP_SPARE = 3'd5;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;   // opcode, key
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;   // found, answer

	int fail_count;
	int pending;
	int src_gap_max;
	int rx_gap_max;

	hierarchical_bitmap_set_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	hbs_check u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = ~clk;
		end
	end

	task automatic send(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
		int gap;
		gap = $urandom_range(0, src_gap_max);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{PAD_W{1'b0}}, key, op};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	function automatic logic [OP_W-1:0] pick_op(int ins_pct, int rem_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < 3) begin
			return OP_SPARE + OP_W'($urandom_range(0, 2));
		end
		r = $urandom_range(0, 99);
		if (r < ins_pct) begin
			return OP_INSERT;
		end
		if (r < ins_pct + rem_pct) begin
			return OP_REMOVE;
		end
		case ($urandom_range(0, 2))
			0: begin
				return OP_CONTAINS;
			end
			1: begin
				return OP_MIN;
			end
			default: begin
				return OP_SUCC;
			end
		endcase
	endfunction

	function automatic logic [KEY_W-1:0] pick_key(int unsigned base);
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return KEY_W'(base + $urandom_range(0, 31));
		end
		if (r < 85) begin
			return KEY_W'($urandom_range(0, KEY_MAX));
		end
		if ($urandom_range(0, 1) == 0) begin
			return KEY_W'($urandom_range(0, 1));
		end
		return KEY_W'(KEY_MAX - $urandom_range(0, 1));
	endfunction

	// keys cluster in a window so removes and successor searches hit members
	task automatic run_phase(int items, int ins_pct, int rem_pct);
		int unsigned base;
		base = $urandom_range(0, KEY_MAX - 31);
		repeat (items) begin
			send(pick_op(ins_pct, rem_pct), pick_key(base));
		end
	endtask

	initial begin : sink
		int gap;
		int n_rx;
		n_rx          = 0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = (n_rx == HOLD_AT) ? HOLD_CYCLES : $urandom_range(0, rx_gap_max);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			n_rx++;
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("%0t: no beat accepted for %0d cycles", $time, quiet);
		$display("hierarchical_bitmap_set_top regression: fail");
		$finish;
	end

	initial begin : stim
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		src_gap_max   = 4;
		rx_gap_max    = 4;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// empty set
		send(OP_MIN, '0);
		send(OP_SUCC, '0);
		send(OP_CONTAINS, '1);
		// extremes, duplicate insert
		send(OP_INSERT, '0);
		send(OP_INSERT, '1);
		send(OP_INSERT, '1);
		send(OP_INSERT, KEY_W'(512));
		send(OP_CONTAINS, '0);
		send(OP_CONTAINS, '1);
		send(OP_CONTAINS, KEY_W'(1));
		send(OP_MIN, '0);
		send(OP_SUCC, '0);
		send(OP_SUCC, KEY_W'(512));
		send(OP_SUCC, '1);
		// remove of a non-member, then empty the set again
		send(OP_REMOVE, KEY_W'(5));
		send(OP_REMOVE, '0);
		send(OP_MIN, '0);
		send(OP_REMOVE, KEY_W'(512));
		send(OP_REMOVE, '1);
		send(OP_MIN, '1);
		send(OP_SUCC, KEY_W'(KEY_MAX - 1));
		// spare opcodes
		send(OP_SPARE, '1);
		send(OP_SPARE + OP_W'(1), KEY_W'(10'h155));
		send(OP_SPARE + OP_W'(2), KEY_W'(10'h2aa));

		run_phase(120, 65, 10);
		src_gap_max <= 0;
		rx_gap_max  <= 0;
		run_phase(80, 40, 25);
		wait_drained();
		src_gap_max <= 4;
		rx_gap_max  <= 2;
		run_phase(150, 35, 30);
		src_gap_max <= 2;
		rx_gap_max  <= 4;
		run_phase(180, 10, 65);

		wait_drained();
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("hierarchical_bitmap_set_top regression: pass");
		end else begin
			$display("hierarchical_bitmap_set_top regression: fail");
		end
		$finish;
	end

endmodule

// ===== hierarchical_bitmap_set_top.f =====
rtl/hbs_pkg.sv
rtl/hbs_ram.sv
rtl/hbs_ctrl.sv
rtl/hbs_dp.sv
rtl/hierarchical_bitmap_set_top.sv
bench/hbs_check.sv
bench/tb.sv
